@@ hdl/mpc_pkg.sv @@
// Shared types, constants and reset values for the modem pin cross-connect.
package mpc_pkg;

    localparam int NUM_IN      = 6;
    localparam int PIN_W       = 9;
    localparam int MAP_W       = 2 * PIN_W;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNT_WIDTH = 16;

    // Level vector bit positions
    localparam int LV_BREAK    = 4;
    localparam int LV_CONNECT  = 5;

    typedef enum logic [2:0] {
        MODE_STATUS  = 3'd0,
        MODE_BREAK   = 3'd1,
        MODE_CONNECT = 3'd2,
        MODE_PASS    = 3'd3,
        MODE_INIT    = 3'd4
    } mode_t;

    typedef logic [MAP_W-1:0]       map_t;
    typedef map_t [NUM_IN-1:0]      map_arr_t;
    typedef logic [PIN_W-1:0]       pins_t;
    typedef logic [NUM_IN-1:0]      levels_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Register order: CTS, DSR, DCD, RI, break, connect
    localparam map_arr_t MAP_RESET = {
        map_t'(0), map_t'(0), map_t'(0), map_t'(0), map_t'(1026), map_t'(513)
    };

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] status_mask;
        logic [3:0] status_value;
        logic       flag_value;
        pins_t      pin_set_mask;
        pins_t      pin_set_value;
    } evt_t;

    typedef struct packed {
        pins_t pin_mask;
        pins_t pin_value;
        logic  is_passthrough;
    } cmd_t;

    // Evaluation result handed back to the top level
    typedef struct packed {
        logic    emit;
        cmd_t    cmd;
        levels_t levels;
        count_t  count;
    } eval_t;

endpackage

@@ hdl/mpc_ifs.sv @@
// Request channel interfaces: events in, pin-set commands out.
interface mpc_evt_if;
    import mpc_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [3:0] status_mask;
    logic [3:0] status_value;
    logic       flag_value;
    pins_t      pin_set_mask;
    pins_t      pin_set_value;

    modport source (output valid, mode, status_mask, status_value, flag_value,
                    pin_set_mask, pin_set_value, input ready);
    modport sink   (input valid, mode, status_mask, status_value, flag_value,
                    pin_set_mask, pin_set_value, output ready);
endinterface

interface mpc_cmd_if;
    import mpc_pkg::*;
    logic  valid;
    logic  ready;
    pins_t pin_mask;
    pins_t pin_value;
    logic  is_passthrough;

    modport source (output valid, pin_mask, pin_value, is_passthrough, input ready);
    modport sink   (input valid, pin_mask, pin_value, is_passthrough, output ready);
endinterface

@@ hdl/mpc_cfg_regs.sv @@
// Route map registers, one per input signal.
module mpc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpc_pkg::MAP_W-1:0]      cfg_data,
    output mpc_pkg::map_arr_t              maps
);
    import mpc_pkg::*;

    map_arr_t maps_reg;
    map_arr_t maps_next;

    always_comb
    begin
        maps_next = maps_reg;
        for (int i = 0; i < NUM_IN; i++)
        begin
            if (cfg_we && cfg_index == CFG_IDX_W'(i))
            begin
                maps_next[i] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maps_reg <= MAP_RESET;
        end
        else
        begin
            maps_reg <= maps_next;
        end
    end

    assign maps = maps_reg;

endmodule

@@ hdl/mpc_eval.sv @@
// Single-pass evaluation of one event: new levels, counter and pin command.
module mpc_eval (
    input  mpc_pkg::evt_t     evt,
    input  mpc_pkg::map_arr_t maps,
    input  mpc_pkg::levels_t  levels,
    input  mpc_pkg::count_t   count,
    output mpc_pkg::eval_t    res
);
    import mpc_pkg::*;

    levels_t used;
    pins_t   driven;
    levels_t nv;
    count_t  cnt_n;
    levels_t sel;
    levels_t sel_lv;
    levels_t upd;
    pins_t   gmask;
    pins_t   gval;
    pins_t   m;
    pins_t   f;

    always_comb
    begin
        used   = '0;
        driven = '0;
        for (int i = 0; i < NUM_IN; i++)
        begin
            used[i] = |maps[i][PIN_W-1:0];
            driven  = driven | maps[i][PIN_W-1:0];
        end
    end

    always_comb
    begin
        nv     = levels;
        cnt_n  = count;
        sel    = '0;
        sel_lv = levels;
        upd    = '0;
        res    = '0;
        case (evt.mode)
            MODE_STATUS:
            begin
                upd[3:0] = evt.status_mask & used[3:0];
                nv[3:0]  = (evt.status_value & upd[3:0]) | (levels[3:0] & ~upd[3:0]);
                sel      = levels ^ nv;
                sel_lv   = nv;
            end
            MODE_BREAK:
            begin
                if (used[LV_BREAK])
                begin
                    nv[LV_BREAK] = evt.flag_value;
                    sel          = levels ^ nv;
                    sel_lv       = nv;
                end
            end
            MODE_CONNECT:
            begin
                if (used[LV_CONNECT])
                begin
                    if (evt.flag_value)
                    begin
                        if (count != '1)
                        begin
                            cnt_n = count + COUNT_WIDTH'(1);
                        end
                    end
                    else if (count != '0)
                    begin
                        cnt_n = count - COUNT_WIDTH'(1);
                    end
                    nv[LV_CONNECT] = (cnt_n != '0);
                    sel            = levels ^ nv;
                    sel_lv         = nv;
                end
            end
            MODE_INIT:
            begin
                sel = used;
            end
            default:
            begin
                sel = '0;
            end
        endcase

        // OR together the routes of the selected inputs
        gmask = '0;
        gval  = '0;
        for (int i = 0; i < NUM_IN; i++)
        begin
            m = maps[i][PIN_W-1:0];
            f = maps[i][MAP_W-1:PIN_W];
            if (sel[i])
            begin
                gmask = gmask | m;
                gval  = gval | ((sel_lv[i] ? f : ~f) & m);
            end
        end

        res.levels = nv;
        res.count  = cnt_n;
        if (evt.mode == MODE_PASS)
        begin
            res.emit               = 1'b1;
            res.cmd.pin_mask       = evt.pin_set_mask & ~driven;
            res.cmd.pin_value      = evt.pin_set_value;
            res.cmd.is_passthrough = 1'b1;
        end
        else
        begin
            res.emit               = (gmask != '0);
            res.cmd.pin_mask       = gmask;
            res.cmd.pin_value      = gval;
            res.cmd.is_passthrough = 1'b0;
        end
    end

endmodule

@@ hdl/modem_pin_crossconnect_core.sv @@
// Modem pin cross-connect: routes six serial-line inputs to nine output pins.
//
// Usage:
//   evt  - event requests (modem status, break, connect/disconnect,
//          pin-set pass-through, init), valid/ready handshake.
//   cmd  - pin-set command requests out; zero or one per event. Generated
//          events that touch no routed pin produce nothing; pass-through always emits.
//   cfg_we/cfg_index/cfg_data - write-only route map registers 0..5 (CTS, DSR,
//          DCD, RI, break, connect). Write only while the block is idle.
// Flow: an accepted event waits in the input register until the command register is
//   free or draining; then its command, if any, loads there and stays on cmd until taken.
// Throughput: one event per cycle; the input register and the command
//   register each hold one request, so a new event is taken while a finished
//   command waits on cmd. When cmd stalls, both stages fill and evt.ready
//   drops until cmd.ready returns.
// Reset: levels and connection counter clear, route maps take their defaults
//   (RTS follows CTS, DTR follows DSR), both pipeline stages empty.
module modem_pin_crossconnect_core (
    input  logic                          clk,
    input  logic                          rst_n,
    mpc_evt_if.sink                       evt,
    mpc_cmd_if.source                     cmd,
    input  logic                          cfg_we,
    input  logic [mpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpc_pkg::MAP_W-1:0]     cfg_data
);
    import mpc_pkg::*;

    map_arr_t maps;
    eval_t    ev;

    logic     in_valid_reg;
    evt_t     in_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    cmd_t     out_reg;
    levels_t  levels_reg;
    count_t   count_reg;
    logic     advance;
    logic     take;

    mpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .maps      (maps)
    );

    mpc_eval u_eval (
        .evt    (in_reg),
        .maps   (maps),
        .levels (levels_reg),
        .count  (count_reg),
        .res    (ev)
    );

    assign advance   = !out_valid_reg || cmd.ready;
    assign evt.ready = !in_valid_reg || advance;
    assign take      = evt.valid && evt.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !cmd.ready;
        if (advance && in_valid_reg)
        begin
            out_valid_next = ev.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            levels_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg)
            begin
                levels_reg <= ev.levels;
                count_reg  <= ev.count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.mode          <= evt.mode;
            in_reg.status_mask   <= evt.status_mask;
            in_reg.status_value  <= evt.status_value;
            in_reg.flag_value    <= evt.flag_value;
            in_reg.pin_set_mask  <= evt.pin_set_mask;
            in_reg.pin_set_value <= evt.pin_set_value;
        end
        if (advance && in_valid_reg && ev.emit)
        begin
            out_reg <= ev.cmd;
        end
    end

    assign cmd.valid          = out_valid_reg;
    assign cmd.pin_mask       = out_reg.pin_mask;
    assign cmd.pin_value      = out_reg.pin_value;
    assign cmd.is_passthrough = out_reg.is_passthrough;

endmodule

@@ hdl/mpc_check.sv @@
// Port-level checks for the cross-connect core, bound to the top level.
module mpc_check (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      evt_ready,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic [mpc_pkg::PIN_W-1:0] cmd_pin_mask,
    input logic                      cmd_is_passthrough
);
    import mpc_pkg::*;

    // A waiting command stays until taken
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("command dropped while stalled");

    // Generated commands always set at least one pin
    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_is_passthrough |-> cmd_pin_mask != '0)
        else $error("generated command with empty mask");

    // A draining output never blocks new events
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> evt_ready)
        else $error("event refused while output drains");

    // Leaving reset, nothing is pending on the output
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !cmd_valid)
        else $error("command pending after reset");

endmodule

bind modem_pin_crossconnect_core mpc_check u_mpc_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt_ready          (evt.ready),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .cmd_pin_mask       (cmd.pin_mask),
    .cmd_is_passthrough (cmd.is_passthrough)
);

@@ tb/sv/modem_pin_crossconnect_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the modem pin cross-connect core.
module modem_pin_crossconnect_core_test;
    import mpc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 50000;
    localparam int BLOCK_EVENTS  = 122;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_REPORTS   = 10;
    localparam int SWEEP_STEPS   = 8;

    // Mode codes the block ignores
    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CTS,
        REG_DSR,
        REG_DCD,
        REG_RING,
        REG_BREAK,
        REG_CONNECT
    } route_sel_t;

    typedef struct {
        bit         is_write;
        evt_t       ev;
        route_sel_t sel;
        map_t       data;
        bit         typed;
        bit         emit;
        cmd_t       cmd;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    map_t                 cfg_data;

    mpc_evt_if evt_ch ();
    mpc_cmd_if cmd_ch ();

    modem_pin_crossconnect_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_ch),
        .cmd       (cmd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    map_arr_t route_map = MAP_RESET;
    levels_t  line_levels = '0;
    count_t   conn_count = '0;

    cmd_t pending_cmds[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int error_count   = 0;
    int cmds_checked  = 0;
    int events_sent   = 0;
    int route_settings = 1;
    int cycle_count   = 0;

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d requests still pending",
                     cycle_count, pending_cmds.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input cmd_t want, input cmd_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch (%s) cycle %0d: exp mask %03h val %03h pt %0b, got mask %03h val %03h pt %0b",
                     what, cycle_count, want.pin_mask, want.pin_value, want.is_passthrough,
                     got.pin_mask, got.pin_value, got.is_passthrough);
    endtask

    // Pin-set command for the inputs in sel at levels lv; returns 0 when no pin is touched.
    function automatic bit pin_command(input levels_t sel, input levels_t lv, output cmd_t c);
        pins_t m;
        pins_t f;
        c = '0;
        for (int i = 0; i < NUM_IN; i++)
        begin
            if (sel[i])
            begin
                m = route_map[i][PIN_W-1:0];
                f = route_map[i][MAP_W-1:PIN_W];
                c.pin_mask  |= m;
                c.pin_value |= lv[i] ? (f & m) : (~f & m);
            end
        end
        return c.pin_mask != '0;
    endfunction

    function automatic bit route_event(input evt_t e, output cmd_t c);
        levels_t    used;
        levels_t    next_lv;
        levels_t    changed;
        pins_t      driven;
        logic [3:0] upd;
        bit         touch;
        bit         emit;
        used   = '0;
        driven = '0;
        for (int i = 0; i < NUM_IN; i++)
        begin
            used[i] = route_map[i][PIN_W-1:0] != '0;
            driven |= route_map[i][PIN_W-1:0];
        end
        next_lv = line_levels;
        touch   = 1'b0;
        emit    = 1'b0;
        c       = '0;
        case (e.mode)
            MODE_STATUS:
            begin
                upd = e.status_mask & used[3:0];
                next_lv[3:0] = (e.status_value & upd) | (line_levels[3:0] & ~upd);
                touch = 1'b1;
            end
            MODE_BREAK:
            begin
                if (used[LV_BREAK])
                begin
                    next_lv[LV_BREAK] = e.flag_value;
                    touch = 1'b1;
                end
            end
            MODE_CONNECT:
            begin
                if (used[LV_CONNECT])
                begin
                    if (e.flag_value && conn_count != '1)
                        conn_count++;
                    else if (!e.flag_value && conn_count != '0)
                        conn_count--;
                    next_lv[LV_CONNECT] = conn_count != '0;
                    touch = 1'b1;
                end
            end
            MODE_PASS:
            begin
                c.pin_mask       = e.pin_set_mask & ~driven;
                c.pin_value      = e.pin_set_value;
                c.is_passthrough = 1'b1;
                emit = 1'b1;
            end
            MODE_INIT:
                emit = pin_command(used, line_levels, c);
            default:
                ;
        endcase
        if (touch)
        begin
            changed     = line_levels ^ next_lv;
            line_levels = next_lv;
            emit        = pin_command(changed, line_levels, c);
        end
        return emit;
    endfunction

    function automatic stim_row_t event_row(input logic [2:0] mode, input logic [3:0] smask,
                                            input logic [3:0] sval, input logic flag,
                                            input pins_t psm, input pins_t psv);
        stim_row_t r;
        r = '{is_write: 1'b0, ev: '0, sel: REG_CTS, data: '0, typed: 1'b0, emit: 1'b0,
              cmd: '0};
        r.ev.mode          = mode;
        r.ev.status_mask   = smask;
        r.ev.status_value  = sval;
        r.ev.flag_value    = flag;
        r.ev.pin_set_mask  = psm;
        r.ev.pin_set_value = psv;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input stim_row_t r, input bit emit,
                                            input pins_t pm, input pins_t pv, input logic pt);
        r.typed              = 1'b1;
        r.emit               = emit;
        r.cmd.pin_mask       = pm;
        r.cmd.pin_value      = pv;
        r.cmd.is_passthrough = pt;
        return r;
    endfunction

    function automatic stim_row_t write_row(input route_sel_t sel, input map_t data);
        stim_row_t r;
        r = '{is_write: 1'b0, ev: '0, sel: REG_CTS, data: '0, typed: 1'b0, emit: 1'b0,
              cmd: '0};
        r.is_write = 1'b1;
        r.sel      = sel;
        r.data     = data;
        return r;
    endfunction

    function automatic map_t random_map();
        pins_t m;
        pins_t f;
        int    roll;
        roll = $urandom_range(99);
        f = pins_t'($urandom_range(511));
        if (roll < 12)
            m = '0;
        else if (roll < 20)
            m = '1;
        else if (roll < 60)
            m = pins_t'(1 << $urandom_range(PIN_W - 1));
        else
            m = pins_t'($urandom_range(511));
        return {f, m};
    endfunction

    function automatic evt_t random_event();
        evt_t e;
        int   roll;
        roll = $urandom_range(99);
        e.status_mask   = 4'($urandom_range(15));
        e.status_value  = 4'($urandom_range(15));
        e.flag_value    = 1'($urandom_range(1));
        e.pin_set_mask  = pins_t'($urandom_range(511));
        e.pin_set_value = pins_t'($urandom_range(511));
        if (roll < 35)
            e.mode = MODE_STATUS;
        else if (roll < 50)
            e.mode = MODE_BREAK;
        else if (roll < 70)
            e.mode = MODE_CONNECT;
        else if (roll < 83)
            e.mode = MODE_PASS;
        else if (roll < 94)
            e.mode = MODE_INIT;
        else
        begin
            case ($urandom_range(2))
                0:       e.mode = MODE_RSVD5;
                1:       e.mode = MODE_RSVD6;
                default: e.mode = MODE_RSVD7;
            endcase
        end
        return e;
    endfunction

    task automatic send_event(input evt_t ev, input bit typed, input bit t_emit,
                              input cmd_t t_cmd);
        cmd_t c;
        bit   emit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid         <= 1'b1;
        evt_ch.mode          <= ev.mode;
        evt_ch.status_mask   <= ev.status_mask;
        evt_ch.status_value  <= ev.status_value;
        evt_ch.flag_value    <= ev.flag_value;
        evt_ch.pin_set_mask  <= ev.pin_set_mask;
        evt_ch.pin_set_value <= ev.pin_set_value;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        emit = route_event(ev, c);
        if (typed)
        begin
            emit = t_emit;
            c    = t_cmd;
        end
        if (emit)
            pending_cmds.push_back(c);
        events_sent++;
    endtask

    // Stop offering requests, let every expected command drain, then let the pipe empty.
    task automatic settle_block();
        evt_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_route(input route_sel_t sel, input map_t data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        route_map[sel] = data;
    endtask

    task automatic program_routes(input map_arr_t maps);
        settle_block();
        for (int i = 0; i < NUM_IN; i++)
            write_route(route_sel_t'(i), maps[i]);
        cfg_we <= 1'b0;
        route_settings++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        cmd_t got;
        cmd_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            got.pin_mask       = cmd_ch.pin_mask;
            got.pin_value      = cmd_ch.pin_value;
            got.is_passthrough = cmd_ch.is_passthrough;
            if (pending_cmds.size() == 0)
                report_mismatch("no request pending", '0, got);
            else
            begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (got.pin_mask !== want.pin_mask)
                    report_mismatch("pin_mask", want, got);
                else if (got.pin_value !== want.pin_value)
                    report_mismatch("pin_value", want, got);
                else if (got.is_passthrough !== want.is_passthrough)
                    report_mismatch("is_passthrough", want, got);
            end
        end
    end

    // Command receiver; a hold request stalls it, otherwise ready is random
    initial
    begin
        int hold_left;
        hold_left = 0;
        cmd_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                cmd_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                cmd_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        stim_row_t directed_rows[$];
        stim_row_t row;
        map_arr_t  maps;
        evt_t      ev;
        int        base;
        bit        paused;
        bit        prev_write;

        evt_ch.valid         = 1'b0;
        evt_ch.mode          = MODE_STATUS;
        evt_ch.status_mask   = '0;
        evt_ch.status_value  = '0;
        evt_ch.flag_value    = 1'b0;
        evt_ch.pin_set_mask  = '0;
        evt_ch.pin_set_value = '0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;

        // Reset routes: RTS follows CTS, DTR follows DSR
        directed_rows.push_back(typed_row(event_row(MODE_INIT, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000),
                                          1'b1, 9'h003, 9'h000, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_STATUS, 4'hF, 4'hF, 1'b0, 9'h000, 9'h000),
                                          1'b1, 9'h003, 9'h003, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_STATUS, 4'hF, 4'hF, 1'b1, 9'h1FF, 9'h1FF),
                                          1'b0, 9'h000, 9'h000, 1'b0));
        // break and connect inputs not routed: nothing happens
        directed_rows.push_back(typed_row(event_row(MODE_BREAK, 4'h0, 4'h0, 1'b1, 9'h000, 9'h000),
                                          1'b0, 9'h000, 9'h000, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_CONNECT, 4'h0, 4'h0, 1'b1, 9'h000, 9'h000),
                                          1'b0, 9'h000, 9'h000, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_PASS, 4'h0, 4'h0, 1'b0, 9'h1FF, 9'h1FF),
                                          1'b1, 9'h1FC, 9'h1FF, 1'b1));
        directed_rows.push_back(typed_row(event_row(MODE_PASS, 4'hF, 4'hF, 1'b1, 9'h000, 9'h000),
                                          1'b1, 9'h000, 9'h000, 1'b1));
        directed_rows.push_back(typed_row(event_row(MODE_RSVD5, 4'hF, 4'hF, 1'b1, 9'h1FF, 9'h1FF),
                                          1'b0, 9'h000, 9'h000, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_RSVD6, 4'hF, 4'h0, 1'b1, 9'h1FF, 9'h1FF),
                                          1'b0, 9'h000, 9'h000, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_RSVD7, 4'hF, 4'h0, 1'b0, 9'h1FF, 9'h000),
                                          1'b0, 9'h000, 9'h000, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_STATUS, 4'h1, 4'h0, 1'b0, 9'h000, 9'h000),
                                          1'b1, 9'h001, 9'h000, 1'b0));
        // Extreme routes: CTS drives everything, DCD inverts onto everything,
        // RI has follow bits but no pins
        directed_rows.push_back(write_row(REG_CTS, 18'h3FFFF));
        directed_rows.push_back(write_row(REG_DSR, 18'h00000));
        directed_rows.push_back(write_row(REG_DCD, 18'h001FF));
        directed_rows.push_back(write_row(REG_RING, 18'h3FE00));
        directed_rows.push_back(write_row(REG_BREAK, 18'h20100));
        directed_rows.push_back(write_row(REG_CONNECT, 18'h00080));
        directed_rows.push_back(event_row(MODE_INIT, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_STATUS, 4'hF, 4'h0, 1'b0, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_STATUS, 4'hF, 4'hF, 1'b0, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_BREAK, 4'h0, 4'h0, 1'b1, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_BREAK, 4'h0, 4'h0, 1'b1, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_BREAK, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_CONNECT, 4'h0, 4'h0, 1'b1, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_CONNECT, 4'h0, 4'h0, 1'b1, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_CONNECT, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_CONNECT, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000));
        // disconnect with the counter already at zero
        directed_rows.push_back(event_row(MODE_CONNECT, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000));
        directed_rows.push_back(event_row(MODE_PASS, 4'h0, 4'h0, 1'b0, 9'h1FF, 9'h0AA));
        directed_rows.push_back(event_row(MODE_INIT, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000));
        // Nothing routed: init is silent, pass-through keeps the whole mask
        for (int i = 0; i < NUM_IN; i++)
            directed_rows.push_back(write_row(route_sel_t'(i), 18'h00000));
        directed_rows.push_back(typed_row(event_row(MODE_INIT, 4'h0, 4'h0, 1'b0, 9'h000, 9'h000),
                                          1'b0, 9'h000, 9'h000, 1'b0));
        directed_rows.push_back(typed_row(event_row(MODE_PASS, 4'h0, 4'h0, 1'b0, 9'h1FF, 9'h123),
                                          1'b1, 9'h1FF, 9'h123, 1'b1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_write = 1'b0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_write)
            begin
                if (!prev_write)
                    settle_block();
                write_route(row.sel, row.data);
                prev_write = 1'b1;
            end
            else
            begin
                if (prev_write)
                begin
                    cfg_we <= 1'b0;
                    route_settings++;
                end
                send_event(row.ev, row.typed, row.emit, row.cmd);
                prev_write = 1'b0;
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                for (int i = 0; i < NUM_IN; i++)
                    maps[i] = (phase == 1 && blk == 0) ? map_t'('1) : random_map();
                program_routes(maps);
                // long receiver stall while requests keep coming
                if (phase == 2 && blk == 0)
                    hold_request = HOLD_CYCLES;
                base   = events_sent;
                paused = 1'b0;
                while (events_sent - base < BLOCK_EVENTS)
                begin
                    if (blk == 1 && !paused && events_sent - base >= BLOCK_EVENTS / 2)
                    begin
                        settle_block();
                        paused = 1'b1;
                    end
                    send_event(random_event(), 1'b0, 1'b0, '0);
                end
            end
        end

        // Connection counter: climb a few steps, then come back down past zero
        maps = route_map;
        maps[REG_CONNECT] = 18'h10080;
        program_routes(maps);
        ev = '0;
        ev.mode = MODE_CONNECT;
        ev.flag_value = 1'b1;
        repeat (SWEEP_STEPS)
            send_event(ev, 1'b0, 1'b0, '0);
        ev.flag_value = 1'b0;
        while (conn_count != '0)
            send_event(ev, 1'b0, 1'b0, '0);
        send_event(ev, 1'b0, 1'b0, '0);

        settle_block();
        if (pending_cmds.size() != 0)
        begin
            $display("%0d expected commands never arrived", pending_cmds.size());
            error_count += pending_cmds.size();
        end

        $display("covered %0d events, %0d commands checked, %0d route settings",
                 events_sent, cmds_checked, route_settings);
        $display("incl. idle/stall mixes, a long output stall and a counter run down past zero");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ modem_pin_crossconnect_core.f @@
hdl/mpc_pkg.sv
hdl/mpc_ifs.sv
hdl/mpc_cfg_regs.sv
hdl/mpc_eval.sv
hdl/modem_pin_crossconnect_core.sv
hdl/mpc_check.sv
tb/sv/modem_pin_crossconnect_core_test.sv
